// ===== design/sec2cal_pkg.sv =====
// Shared types, constants and table functions for the seconds-to-calendar converter.
package sec2cal_pkg;

  localparam int unsigned InWidth    = 32;
  localparam int unsigned OutWidth   = 48;
  localparam int unsigned DivCycles  = InWidth / 2;
  localparam int unsigned CntWidth   = $clog2(DivCycles);
  localparam int unsigned DaysWidth  = 16;
  localparam int unsigned EpochYear  = 2000;
  localparam int unsigned EpochWday  = 6;
  localparam int unsigned LastFeb28  = 58;
  localparam int unsigned LastMonth  = 11;
  localparam int unsigned MaxYearOff = 136;

  typedef enum logic [1:0] {
    FLD_SEC  = 2'd0,
    FLD_MIN  = 2'd1,
    FLD_HR   = 2'd2,
    FLD_WDAY = 2'd3
  } fld_e;

  typedef struct packed {
    logic load_in;
    logic div_step;
    fld_e fld;
    logic year_step;
    logic feb_adj;
    logic month_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic year_fit;
    logic month_fit;
    logic out_free;
  } sts_t;

  function automatic logic [6:0] divisor(input fld_e fld);
    logic [6:0] dv;
    unique case (fld)
      FLD_SEC:  dv = 7'd60;
      FLD_MIN:  dv = 7'd60;
      FLD_HR:   dv = 7'd24;
      FLD_WDAY: dv = 7'd7;
      default:  dv = 7'd60;
    endcase
    return dv;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon);
    logic [4:0] len;
    unique case (mon)
      4'd0:    len = 5'd31;
      4'd1:    len = 5'd29;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== design/sec2cal_dp.sv =====
// Datapath of the seconds-to-calendar converter: divider, year and month walks, output word.
module sec2cal_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  sec2cal_pkg::cmd_t                    cmd_i,
  output sec2cal_pkg::sts_t                    sts_o,
  input  logic [sec2cal_pkg::InWidth-1:0]      in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [sec2cal_pkg::OutWidth-1:0]     out_data_o
);
  import sec2cal_pkg::*;

  logic [InWidth-1:0]   work_q, work_d;
  logic [5:0]           rem_q, rem_d;
  logic [CntWidth-1:0]  cnt_q;
  logic [5:0]           sec_q, min_q;
  logic [4:0]           hr_q;
  logic [2:0]           wday_q;
  logic [DaysWidth-1:0] days_q;
  logic [7:0]           yoff_q;
  logic [3:0]           mon_q;
  logic                 out_valid_q;
  logic [OutWidth-1:0]  out_data_q;

  logic [6:0]           dv, r_a, r_a1, r_b, r_b1;
  logic                 bit_a, bit_b, leap, div_last;
  logic [8:0]           ylen;
  logic [4:0]           mlen;
  logic [11:0]          year;
  logic [4:0]           dom;

  always_comb begin
    dv    = divisor(cmd_i.fld);
    r_a   = {rem_q, work_q[InWidth-1]};
    bit_a = (r_a >= dv);
    r_a1  = bit_a ? (r_a - dv) : r_a;
    r_b   = {r_a1[5:0], work_q[InWidth-2]};
    bit_b = (r_b >= dv);
    r_b1  = bit_b ? (r_b - dv) : r_b;
    work_d = {work_q[InWidth-3:0], bit_a, bit_b};
    rem_d  = r_b1[5:0];
  end

  assign div_last = (cnt_q == CntWidth'(DivCycles - 1));
  assign leap = (yoff_q[1:0] == 2'd0) && (yoff_q != 8'd100) && (yoff_q != 8'd200);
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = month_len(mon_q);
  assign year = 12'(EpochYear) + 12'(yoff_q);
  assign dom  = days_q[4:0] + 5'd1;

  assign sts_o.div_last  = div_last;
  assign sts_o.year_fit  = (days_q < DaysWidth'(ylen));
  assign sts_o.month_fit = (mon_q == 4'(LastMonth)) || (days_q < DaysWidth'(mlen));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_in) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + CntWidth'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      work_q <= in_data_i;
      rem_q  <= '0;
      yoff_q <= '0;
      mon_q  <= '0;
    end else if (cmd_i.div_step) begin
      work_q <= (div_last && (cmd_i.fld == FLD_HR)) ? work_d + InWidth'(EpochWday) : work_d;
      rem_q  <= div_last ? '0 : rem_d;
      if (div_last) begin
        case (cmd_i.fld)
          FLD_SEC:  sec_q  <= rem_d;
          FLD_MIN:  min_q  <= rem_d;
          FLD_HR: begin
            hr_q   <= rem_d[4:0];
            days_q <= work_d[DaysWidth-1:0];
          end
          FLD_WDAY: wday_q <= rem_d[2:0];
          default:  sec_q  <= rem_d;
        endcase
      end
    end
    if (cmd_i.year_step && !sts_o.year_fit) begin
      days_q <= days_q - DaysWidth'(ylen);
      yoff_q <= yoff_q + 8'd1;
    end
    if (cmd_i.feb_adj && !leap && (days_q > DaysWidth'(LastFeb28))) begin
      days_q <= days_q + DaysWidth'(1);
    end
    if (cmd_i.month_step && !sts_o.month_fit) begin
      days_q <= days_q - DaysWidth'(mlen);
      mon_q  <= mon_q + 4'd1;
    end
    if (cmd_i.out_load) begin
      out_data_q <= {7'd0, dom, mon_q, year, wday_q, hr_q, min_q, sec_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_d < dv[5:0]))
    else $error("divider remainder not below divisor");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.month_step |-> (mon_q <= 4'(LastMonth)))
    else $error("month index out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.month_step |-> (yoff_q <= 8'(MaxYearOff)))
    else $error("year offset out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_q)
    else $error("output word lost at load");
`endif

endmodule

// ===== design/sec2cal_ctrl.sv =====
// Controller state machine of the seconds-to-calendar converter.
module sec2cal_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output sec2cal_pkg::cmd_t cmd_o,
  input  sec2cal_pkg::sts_t sts_i
);
  import sec2cal_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_YEAR  = 6'b000100,
    ST_FEB   = 6'b001000,
    ST_MONTH = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  fld_e   fld_q, fld_d;

  always_comb begin
    state_d = state_q;
    fld_d   = fld_q;
    cmd_o   = '0;
    cmd_o.fld = fld_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          fld_d   = FLD_SEC;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          unique case (fld_q)
            FLD_SEC:  fld_d = FLD_MIN;
            FLD_MIN:  fld_d = FLD_HR;
            FLD_HR:   fld_d = FLD_WDAY;
            FLD_WDAY: state_d = ST_YEAR;
            default:  state_d = ST_YEAR;
          endcase
        end
      end
      ST_YEAR: begin
        cmd_o.year_step = 1'b1;
        if (sts_i.year_fit) begin
          state_d = ST_FEB;
        end
      end
      ST_FEB: begin
        cmd_o.feb_adj = 1'b1;
        state_d = ST_MONTH;
      end
      ST_MONTH: begin
        cmd_o.month_step = 1'b1;
        if (sts_i.month_fit) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fld_q   <= FLD_SEC;
    end else begin
      state_q <= state_d;
      fld_q   <= fld_d;
    end
  end

endmodule

// ===== design/seconds_to_calendar_date.sv =====
// Top level of the converter from epoch seconds to calendar date fields.
//
// Channel  Dir  Word contents
// s_*      in   tdata[31:0] seconds_count
// m_*      out  tdata[47:0] second, minute, hour, weekday, year, month, day_of_month
//
// After acceptance a word passes through four divisions at two quotient bits per cycle, the year
// walk, the February adjustment, the month walk and the output load before its result is valid.
// The input accepts a new word only while the controller is idle.
// A finished result waits in the output register, and the next word may already be taken.
// Reset clears the controller and the output valid flag.
module seconds_to_calendar_date (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [31:0] s_tdata_i,  // [31:0] seconds_count
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [47:0] m_tdata_o   // second, minute, hour, weekday, year, month, day_of_month
);
  import sec2cal_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sec2cal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid_i),
    .in_ready_o (s_tready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  sec2cal_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_tdata_i),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .out_data_o  (m_tdata_o)
  );

endmodule

// ===== test/tb_seconds_to_calendar_date.sv =====
// Self-checking testbench for the epoch-seconds to calendar-date converter.
`timescale 1ns / 100ps

module tb_seconds_to_calendar_date;
  import sec2cal_pkg::*;

  localparam int unsigned NumWords = 1250;
  localparam int unsigned SettleCycles = 300;
  localparam int unsigned SecsPerDay = 86400;
  localparam int unsigned MonthDays[12] = '{31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [6:0]  pad;
    logic [4:0]  day_of_month;
    logic [3:0]  month;
    logic [11:0] year;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_t;

  typedef struct {
    logic [31:0] secs;
    bit          drain;
  } pending_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [31:0] s_tdata_i = '0;  // [31:0] seconds_count
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [47:0] m_tdata_o;  // second, minute, hour, weekday, year, month, day_of_month

  pending_t    seconds_pending[$];
  cal_t        cal_expected[$];
  bit          in_taken = 1'b0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_directed = 0;
  int unsigned mismatch_cnt = 0;

  seconds_to_calendar_date dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  initial forever #6 clk_i = ~clk_i;

  function automatic bit leap_year(int unsigned yr);
    return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
  endfunction

  function automatic int unsigned year_len(int unsigned yr);
    return leap_year(yr) ? 366 : 365;
  endfunction

  function automatic longint unsigned secs_at(int unsigned yr, int unsigned yday,
                                              int unsigned sod);
    longint unsigned days;
    days = yday;
    for (int unsigned y = EpochYear; y < yr; y++) days += year_len(y);
    return days * SecsPerDay + sod;
  endfunction

  function automatic cal_t to_calendar(logic [31:0] secs);
    cal_t        c;
    int unsigned rest, days, yr, mon;
    c = '0;
    rest = secs;
    c.second = 6'(rest % 60);
    rest = rest / 60;
    c.minute = 6'(rest % 60);
    rest = rest / 60;
    c.hour = 5'(rest % 24);
    days = rest / 24;
    c.weekday = 3'((days + EpochWday) % 7);
    yr = EpochYear;
    while (days >= year_len(yr)) begin
      days -= year_len(yr);
      yr++;
    end
    // The month table carries 29 February, so common years step over it.
    if (!leap_year(yr) && days > LastFeb28) days++;
    mon = 0;
    while (mon < LastMonth && days >= MonthDays[mon]) begin
      days -= MonthDays[mon];
      mon++;
    end
    c.year = 12'(yr);
    c.month = 4'(mon);
    c.day_of_month = 5'(days + 1);
    return c;
  endfunction

  function automatic void push_word(longint unsigned secs, bit drain);
    pending_t p;
    p.secs = secs[31:0];
    p.drain = drain;
    seconds_pending.push_back(p);
  endfunction

  function automatic logic [31:0] random_seconds();
    int unsigned     yr, yday, sod;
    longint unsigned v;
    if ($urandom_range(99) < 35) return $urandom;
    yr = $urandom_range(EpochYear, EpochYear + MaxYearOff);
    case ($urandom_range(3))
      0: yday = $urandom_range(2);
      1: yday = $urandom_range(LastFeb28 - 1, LastFeb28 + 3);
      2: yday = year_len(yr) - 1 - $urandom_range(1);
      default: yday = $urandom_range(year_len(yr) - 1);
    endcase
    case ($urandom_range(2))
      0: sod = $urandom_range(2);
      1: sod = SecsPerDay - 1 - $urandom_range(2);
      default: sod = $urandom_range(SecsPerDay - 1);
    endcase
    v = secs_at(yr, yday, sod);
    return (v > 64'hFFFF_FFFF) ? $urandom : v[31:0];
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    cal_t got, want;
    in_taken <= s_tvalid_i && s_tready_o;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_o) cal_expected.push_back(to_calendar(s_tdata_i));
      if (m_tvalid_o && m_tready_i) begin
        got = cal_t'(m_tdata_o);
        if (cal_expected.size() == 0) begin
          $error("result word with no conversion pending");
          mismatch_cnt++;
        end else begin
          want = cal_expected.pop_front();
          check_field("second", want.second, got.second);
          check_field("minute", want.minute, got.minute);
          check_field("hour", want.hour, got.hour);
          check_field("weekday", want.weekday, got.weekday);
          check_field("year", want.year, got.year);
          check_field("month", want.month, got.month);
          check_field("day_of_month", want.day_of_month, got.day_of_month);
          n_checked++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    int unsigned send_idle, recv_idle;
    pending_t    nxt;
    if (n_sent < NumWords / 3) begin
      send_idle = 32;
      recv_idle = 88;
    end else if (n_sent < 2 * NumWords / 3) begin
      send_idle = 88;
      recv_idle = 32;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    if (!rst_ni) begin
      s_tvalid_i <= 1'b0;
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= ($urandom_range(99) >= recv_idle);
      if (!s_tvalid_i || in_taken) begin
        if (seconds_pending.size() > 0 && $urandom_range(99) >= send_idle
            && !(seconds_pending[0].drain && cal_expected.size() > 0)) begin
          nxt = seconds_pending.pop_front();
          s_tvalid_i <= 1'b1;
          s_tdata_i <= nxt.secs;
          n_sent++;
        end else begin
          s_tvalid_i <= 1'b0;
          s_tdata_i <= $urandom;
        end
      end
    end
  end

  initial begin
    push_word(32'd0, 1'b0);
    push_word(32'd59, 1'b0);
    push_word(32'd60, 1'b0);
    push_word(32'd3599, 1'b0);
    push_word(32'd3600, 1'b0);
    push_word(32'd86399, 1'b0);
    push_word(32'd86400, 1'b0);
    push_word(secs_at(2000, 58, 86399), 1'b0);
    push_word(secs_at(2000, 59, 0), 1'b0);
    push_word(secs_at(2000, 60, 0), 1'b0);
    push_word(secs_at(2000, 365, 86399), 1'b0);
    push_word(secs_at(2001, 0, 0), 1'b0);
    push_word(secs_at(2001, 58, 86399), 1'b0);
    push_word(secs_at(2001, 59, 0), 1'b0);
    push_word(secs_at(2099, 364, 86399), 1'b0);
    push_word(secs_at(2100, 58, 86399), 1'b0);
    push_word(secs_at(2100, 59, 0), 1'b0);
    push_word(secs_at(2100, 364, 86399), 1'b0);
    push_word(secs_at(2101, 0, 0), 1'b0);
    push_word(secs_at(2136, 0, 0), 1'b0);
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(32'hFFFF_FFFE, 1'b0);
    push_word(32'h8000_0000, 1'b0);
    push_word(32'h5555_5555, 1'b0);
    push_word(32'hAAAA_AAAA, 1'b0);
    n_directed = seconds_pending.size();
    for (int unsigned i = n_directed; i < NumWords; i++) begin
      push_word(random_seconds(),
                (i == n_directed) || (i == NumWords / 3) || (i == 2 * NumWords / 3));
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (seconds_pending.size() > 0 || s_tvalid_i) @(posedge clk_i);
    while (cal_expected.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Converted %0d words: %0d directed edge cases, the rest random full-range and",
             n_checked, n_directed);
    $display("calendar-boundary values, under sender and receiver stalls and drained pauses.");
    if (mismatch_cnt == 0 && cal_expected.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #48_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
design/sec2cal_pkg.sv
design/sec2cal_dp.sv
design/sec2cal_ctrl.sv
design/seconds_to_calendar_date.sv
test/tb_seconds_to_calendar_date.sv
